[sv/flvs_pkg.sv]
// shared types and constants for the fifo/lru victim select block
// no dependencies; every other file imports this package
package flvs_pkg;

    localparam int FRAME_W = 4;
    localparam int MASK_W  = 16;
    localparam int STAMP_W = 64;
    localparam int Q_DEPTH = 2;

    // command codes carried by an input beat
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ACCESS = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    // one classified operation passed from front to back
    typedef struct packed {
        t_cmd                cmd;
        logic [FRAME_W-1:0]  frame;
        logic [MASK_W-1:0]   mask;
    } t_op;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_DONE
    } t_back_state;

endpackage

[sv/flvs_ifs.sv]
// valid/ready channel interfaces for input, result and config beats
// depends on flvs_pkg
interface flvs_in_if;
    import flvs_pkg::*;

    logic               valid;
    logic               ready;
    t_cmd               cmd;
    logic [FRAME_W-1:0] frame;
    logic [MASK_W-1:0]  evictable_mask;

    modport source (output valid, output cmd, output frame, output evictable_mask,
                    input ready);
    modport sink   (input valid, input cmd, input frame, input evictable_mask,
                    output ready);
endinterface

interface flvs_out_if;
    import flvs_pkg::*;

    logic               valid;
    logic               ready;
    logic               victim_found;
    logic [FRAME_W-1:0] victim_frame;

    modport source (output valid, output victim_found, output victim_frame, input ready);
    modport sink   (input valid, input victim_found, input victim_frame, output ready);
endinterface

interface flvs_cfg_if;
    logic valid;
    logic ready;
    logic policy_mode;

    modport source (output valid, output policy_mode, input ready);
    modport sink   (input valid, input policy_mode, output ready);
endinterface

[sv/flvs_front.sv]
// front end: accepts input beats, holds the policy register, drops out-of-range and fifo-mode access commands
// depends on flvs_pkg and flvs_ifs
module flvs_front #(
    parameter int NUM_FRAMES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    flvs_in_if.sink        i_in,
    flvs_cfg_if.sink       i_cfg,
    output logic           o_push_valid,
    output flvs_pkg::t_op  o_push_op,
    input  logic           i_push_ready
);
    import flvs_pkg::*;

    localparam logic [6:0] FRAME_LIMIT = 7'(NUM_FRAMES);

    logic r_policy;
    logic r_vld, n_vld;
    t_op  r_op, n_op;
    logic keep;
    logic in_fire;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;

    // stage register frees when the queue takes its beat
    assign i_in.ready   = !r_vld || i_push_ready;
    assign in_fire      = i_in.valid && i_in.ready;
    assign o_push_valid = r_vld;
    assign o_push_op    = r_op;

    // queries always pass; other commands need a frame in range, access needs lru
    always_comb begin
        keep = 1'b0;
        case (i_in.cmd)
            CMD_QUERY:  keep = 1'b1;
            CMD_ACCESS: keep = ({3'b000, i_in.frame} < FRAME_LIMIT) && r_policy;
            default:    keep = ({3'b000, i_in.frame} < FRAME_LIMIT);
        endcase
    end

    always_comb begin
        n_vld = r_vld;
        n_op  = r_op;
        if (r_vld && i_push_ready) begin
            n_vld = 1'b0;
        end
        if (in_fire && keep) begin
            n_vld       = 1'b1;
            n_op.cmd    = i_in.cmd;
            n_op.frame  = i_in.frame;
            n_op.mask   = i_in.evictable_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_policy <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg.valid) begin
                r_policy <= i_cfg.policy_mode;
            end
        end
        r_op <= n_op;
    end

endmodule

[sv/flvs_queue.sv]
// short operation queue between front and back end
// depends on flvs_pkg
module flvs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  flvs_pkg::t_op  i_push_op,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output flvs_pkg::t_op  o_pop_op,
    input  logic           i_pop_ready
);
    import flvs_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(Q_DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(Q_DEPTH - 1);

    t_op              r_ent [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_ent[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers wrap at the queue depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_ent[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

[sv/flvs_back.sv]
// back end: stamp memory, logical clock, victim scan and result register
// depends on flvs_pkg and flvs_ifs
module flvs_back #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  flvs_pkg::t_op  i_pop_op,
    output logic           o_pop_ready,
    flvs_out_if.source     o_out
);
    import flvs_pkg::*;

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);

    // stamp memory, valid bits and logical clock
    logic [STAMP_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid, n_valid;
    logic [STAMP_W-1:0] r_clock, n_clock;
    logic               mem_we;
    logic [IDXW-1:0]    wr_addr;

    // sequencer and scan state
    t_back_state        r_st, n_st;
    logic [IDXW-1:0]    r_idx, n_idx;
    logic [MASK_W-1:0]  r_q_mask, n_q_mask;
    logic               r_rd_vld;
    logic               r_rd_ok;
    logic [IDXW-1:0]    r_rd_frame;
    logic [STAMP_W-1:0] r_rd_data;
    logic               r_found, n_found;
    logic [STAMP_W-1:0] r_best, n_best;
    logic [IDXW-1:0]    r_best_frame, n_best_frame;
    logic               hit;

    // result register
    logic               r_out_vld, n_out_vld;
    logic               r_out_found, n_out_found;
    logic [FRAME_W-1:0] r_out_frame, n_out_frame;

    assign o_pop_ready        = (r_st == BK_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.victim_found = r_out_found;
    assign o_out.victim_frame = r_out_frame;
    assign wr_addr            = IDXW'(i_pop_op.frame);

    // candidate: evictable, stamped, and strictly older than the best so far
    assign hit = r_rd_vld && r_rd_ok && (r_rd_data != '0)
                 && (!r_found || (r_rd_data < r_best));

    always_comb begin
        n_st         = r_st;
        n_valid      = r_valid;
        n_clock      = r_clock;
        n_idx        = r_idx;
        n_q_mask     = r_q_mask;
        n_found      = r_found;
        n_best       = r_best;
        n_best_frame = r_best_frame;
        n_out_vld    = r_out_vld;
        n_out_found  = r_out_found;
        n_out_frame  = r_out_frame;
        mem_we       = 1'b0;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_st)
            BK_IDLE: begin
                if (i_pop_valid) begin
                    case (i_pop_op.cmd)
                        CMD_LOAD, CMD_ACCESS: begin
                            mem_we           = 1'b1;
                            n_clock          = r_clock + 1'b1;
                            n_valid[wr_addr] = 1'b1;
                        end
                        CMD_FREE: begin
                            n_valid[wr_addr] = 1'b0;
                        end
                        default: begin
                            n_q_mask     = i_pop_op.mask;
                            n_idx        = '0;
                            n_found      = 1'b0;
                            n_best_frame = '0;
                            n_st         = BK_SCAN;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_st = BK_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            BK_DRAIN: begin
                n_st = BK_DONE;
            end
            BK_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_found;
                    n_out_frame = FRAME_W'(r_best_frame);
                    n_st        = BK_IDLE;
                end
            end
            default: begin
                n_st = BK_IDLE;
            end
        endcase

        // compare stage runs in the cycle after the memory read
        if (hit) begin
            n_found      = 1'b1;
            n_best       = r_rd_data;
            n_best_frame = r_rd_frame;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= BK_IDLE;
            r_valid   <= '0;
            r_clock   <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_valid   <= n_valid;
            r_clock   <= n_clock;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= (r_st == BK_SCAN);
        end
        r_idx        <= n_idx;
        r_q_mask     <= n_q_mask;
        r_found      <= n_found;
        r_best       <= n_best;
        r_best_frame <= n_best_frame;
        r_out_found  <= n_out_found;
        r_out_frame  <= n_out_frame;
        r_rd_ok      <= r_valid[r_idx] && r_q_mask[FRAME_W'(r_idx)];
        r_rd_frame   <= r_idx;
    end

    // stamp memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_clock + 1'b1;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // an empty result always reports frame zero
    a_none_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_found |-> r_out_frame == '0)
        else $error("no-victim result with nonzero frame");

    // a found victim names a stored frame
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_found |-> {1'b0, r_out_frame} < 5'(DEPTH))
        else $error("victim frame beyond stored frames");

    // the clock moves only when a load or access is carried out
    a_clock_only_on_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_st == BK_IDLE && i_pop_valid
          && (i_pop_op.cmd == CMD_LOAD || i_pop_op.cmd == CMD_ACCESS))
        |=> r_clock == $past(r_clock))
        else $error("logical clock changed without a stamp");

    // a result is only produced from the done state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld ##1 r_out_vld |-> $past(r_st) == BK_DONE)
        else $error("result appeared outside done state");

endmodule

[sv/fifo_lru_victim_select.sv]
// top level of the fifo/lru victim select block
// depends on flvs_pkg, flvs_ifs, flvs_front, flvs_queue, flvs_back
//
// usage:
//   i_in carries commands (load, access, free, victim query) with a frame index
//   and an evictable mask; o_out returns one beat per victim query with
//   victim_found and victim_frame; i_cfg writes policy_mode (0 fifo, 1 lru) and
//   is always ready, to be written only while the block is idle.
// back end operation:
//   load, access and free are carried out from the back end idle state; a victim
//   query scans min(NUM_FRAMES,16) frames of the stamp memory, which is read
//   one frame per cycle through its single registered read port, then passes
//   the drain and done states. the front register and a two-entry queue accept
//   beats while a query scan is running.
// reset:
//   synchronous active-low i_rst_n clears all frame valid bits (every frame
//   empty), the logical clock and the policy register.
// stalls:
//   a finished result waits in the output register; the back end holds the
//   next query result until it is taken, and the queue and front register
//   absorb up to three more commands before i_in.ready drops.
module fifo_lru_victim_select #(
    parameter int NUM_FRAMES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    flvs_in_if.sink   i_in,
    flvs_cfg_if.sink  i_cfg,
    flvs_out_if.source o_out
);
    import flvs_pkg::*;

    // frames beyond the mask width can never be named or evicted
    localparam int DEPTH = (NUM_FRAMES < MASK_W) ? NUM_FRAMES : MASK_W;

    logic push_valid, push_ready;
    t_op  push_op;
    logic pop_valid, pop_ready;
    t_op  pop_op;

    // accept and classify
    flvs_front #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .o_push_op    (push_op),
        .i_push_ready (push_ready)
    );

    // decouple front from back
    flvs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_op    (push_op),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_op     (pop_op),
        .i_pop_ready  (pop_ready)
    );

    // stamp store and victim scan
    flvs_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_op    (pop_op),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule
